// ===== hdl/fcf_pkg.sv =====
package fcf_pkg;

	localparam int MAX_TAPS = 512;
	localparam int AW       = $clog2(MAX_TAPS);
	localparam int CNT_W    = AW + 1;
	localparam int DATA_W   = 16;
	localparam int CFG_W    = 10;
	localparam int IDX_W    = 9;
	localparam int PROD_W   = 2 * DATA_W;
	localparam int ACC_W    = PROD_W + AW;
	localparam int FRAC_W   = DATA_W - 1;

	localparam logic signed [ACC_W-1:0] ROUND_HALF = ACC_W'(1 << (FRAC_W - 1));
	localparam logic signed [ACC_W-1:0] SAT_HI     = ACC_W'((1 << FRAC_W) - 1);
	localparam logic signed [ACC_W-1:0] SAT_LO     = ACC_W'(-(1 << FRAC_W));

	localparam logic [1:0] MODE_LOAD   = 2'd0;
	localparam logic [1:0] MODE_FILTER = 2'd1;
	localparam logic [1:0] MODE_CLEAR  = 2'd2;

	typedef enum logic [2:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_RUN,
		ST_DRAIN,
		ST_EMIT
	} state_t;

	typedef struct packed {
		logic vld;
		logic last;
		logic hv;
	} mac_ctl_t;

endpackage

// ===== hdl/fcf_if.sv =====
interface fcf_in_if;
	logic              valid;
	logic              ready;
	logic [1:0]        mode;
	logic [8:0]        tap_index;
	logic signed [15:0] value;

	modport source (output valid, output mode, output tap_index, output value, input ready);
	modport sink (input valid, input mode, input tap_index, input value, output ready);
endinterface

interface fcf_out_if;
	logic               valid;
	logic               ready;
	logic signed [15:0] out_sample;

	modport source (output valid, output out_sample, input ready);
	modport sink (input valid, input out_sample, output ready);
endinterface

// ===== hdl/fcf_ram.sv =====
module fcf_ram (
	input  logic                                clk,
	input  logic                                we,
	input  logic [fcf_pkg::AW-1:0]              waddr,
	input  logic signed [fcf_pkg::DATA_W-1:0]   wdata,
	input  logic [fcf_pkg::AW-1:0]              raddr,
	output logic signed [fcf_pkg::DATA_W-1:0]   rdata
);
	import fcf_pkg::*;

	logic signed [DATA_W-1:0] mem [MAX_TAPS];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		rdata <= mem[raddr];
	end

endmodule

// ===== hdl/fcf_mac.sv =====
module fcf_mac (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              start,
	input  fcf_pkg::mac_ctl_t                 ctl,
	input  logic signed [fcf_pkg::DATA_W-1:0] coef,
	input  logic signed [fcf_pkg::DATA_W-1:0] hist,
	output logic                              done,
	output logic signed [fcf_pkg::DATA_W-1:0] result
);
	import fcf_pkg::*;

	logic signed [PROD_W-1:0] prod_s2;
	mac_ctl_t                 ctl_s2;
	logic signed [ACC_W-1:0]  acc_q;
	logic                     done_q;
	logic signed [ACC_W-1:0]  rnd;
	logic signed [ACC_W-1:0]  shf;
	logic signed [DATA_W-1:0] hist_m;

	// history entries not written since the last clear read as zero
	assign hist_m = ctl.hv ? hist : '0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctl_s2 <= '0;
			done_q <= 1'b0;
		end else begin
			ctl_s2 <= ctl;
			done_q <= ctl_s2.vld & ctl_s2.last;
		end
	end

	always_ff @(posedge clk) begin
		prod_s2 <= coef * hist_m;
		if (start) begin
			acc_q <= '0;
		end else if (ctl_s2.vld) begin
			acc_q <= acc_q + ACC_W'(prod_s2);
		end
	end

	// round half up, then saturate to 16 bits
	always_comb begin
		rnd = acc_q + ROUND_HALF;
		shf = rnd >>> FRAC_W;
		if (shf > SAT_HI) begin
			result = SAT_HI[DATA_W-1:0];
		end else if (shf < SAT_LO) begin
			result = SAT_LO[DATA_W-1:0];
		end else begin
			result = shf[DATA_W-1:0];
		end
	end

	assign done = done_q;

endmodule

// ===== hdl/fir_convolution_filter.sv =====
// Direct-form FIR filter for a Q1.15 sample stream. Each input transfer loads
// one coefficient, filters one sample, or clears the sample history. A sample with
// zero taps in use is returned unchanged; with N taps in use, a single
// multiply-accumulate unit walks the coefficient memory and the history ring
// one tap per cycle, one read port each. The next input transfer is taken
// once the result sits in the output register, even if the sink has not yet
// taken it. After reset the block runs a clearing pass over all 512
// coefficient memory entries and takes no input transfer until it ends;
// tap_count writes are taken at any time and should only be issued while the
// block is idle. Results are rounded half up and saturated to 16 bits.
module fir_convolution_filter (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           tap_count_we,
	input  logic [fcf_pkg::CFG_W-1:0]      tap_count_wdata,
	fcf_in_if.sink                         item,
	fcf_out_if.source                      result
);
	import fcf_pkg::*;

	state_t                   state_q;
	state_t                   nxt_state;

	logic [CNT_W-1:0]         taps_q;     // tap count, saturated to the memory depth
	logic [AW-1:0]            clr_q;      // clearing pass address
	logic [AW-1:0]            ptr_q;      // next history slot
	logic [CNT_W-1:0]         fill_q;     // history slots written since last clear
	logic [CNT_W-1:0]         k_q;        // tap being issued
	logic [AW-1:0]            pos_q;      // history slot being issued
	logic signed [DATA_W-1:0] res_q;
	logic                     out_vld_q;
	logic signed [DATA_W-1:0] out_data_q;
	mac_ctl_t                 ctl_s1;

	logic                     xfer_in;
	logic                     is_load;
	logic                     is_filter;
	logic                     is_clear;
	logic                     idx_ok;
	logic                     issue;
	logic                     last_tap;
	logic                     hist_vld;
	logic                     out_free;
	logic                     out_load;

	logic                     coef_we;
	logic [AW-1:0]            coef_waddr;
	logic signed [DATA_W-1:0] coef_wdata;
	logic signed [DATA_W-1:0] coef_rd;
	logic signed [DATA_W-1:0] hist_rd;
	logic                     mac_done;
	logic signed [DATA_W-1:0] mac_res;

	assign xfer_in   = item.valid & item.ready;
	assign is_load   = item.mode == MODE_LOAD;
	assign is_filter = item.mode == MODE_FILTER;
	assign is_clear  = item.mode == MODE_CLEAR;
	assign idx_ok    = 32'(item.tap_index) < MAX_TAPS;
	assign last_tap  = k_q == taps_q - CNT_W'(1);
	assign out_free  = !out_vld_q || result.ready;

	// a slot holds a live sample once the ring is full or it lies below the fill count
	assign hist_vld  = (fill_q == CNT_W'(MAX_TAPS)) || ({1'b0, pos_q} < fill_q);

	// next state
	always_comb begin
		nxt_state = state_q;
		unique case (state_q)
			ST_CLEAR: begin
				if (clr_q == AW'(MAX_TAPS - 1)) nxt_state = ST_IDLE;
			end
			ST_IDLE: begin
				if (xfer_in && is_filter) begin
					nxt_state = (taps_q == '0) ? ST_EMIT : ST_RUN;
				end
			end
			ST_RUN: begin
				if (last_tap) nxt_state = ST_DRAIN;
			end
			ST_DRAIN: begin
				if (mac_done) nxt_state = ST_EMIT;
			end
			ST_EMIT: begin
				if (out_free) nxt_state = ST_IDLE;
			end
			default: nxt_state = ST_IDLE;
		endcase
	end

	// state outputs
	always_comb begin
		item.ready = 1'b0;
		issue      = 1'b0;
		out_load   = 1'b0;
		coef_we    = 1'b0;
		coef_waddr = AW'(item.tap_index);
		coef_wdata = item.value;
		unique case (state_q)
			ST_CLEAR: begin
				coef_we    = 1'b1;
				coef_waddr = clr_q;
				coef_wdata = '0;
			end
			ST_IDLE: begin
				item.ready = 1'b1;
				coef_we    = item.valid & is_load & idx_ok;
			end
			ST_RUN: begin
				issue = 1'b1;
			end
			ST_DRAIN: begin
			end
			ST_EMIT: begin
				out_load = out_free;
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_CLEAR;
			taps_q    <= '0;
			clr_q     <= '0;
			ptr_q     <= '0;
			fill_q    <= '0;
			k_q       <= '0;
			pos_q     <= '0;
			out_vld_q <= 1'b0;
			ctl_s1    <= '0;
		end else begin
			state_q <= nxt_state;

			// saturate the tap count to the memory depth
			if (tap_count_we) begin
				taps_q <= (32'(tap_count_wdata) > MAX_TAPS) ? CNT_W'(MAX_TAPS)
				                                            : CNT_W'(tap_count_wdata);
			end

			if (state_q == ST_CLEAR) begin
				clr_q <= clr_q + AW'(1);
			end

			if (xfer_in && is_clear) begin
				ptr_q  <= '0;
				fill_q <= '0;
			end else if (xfer_in && is_filter) begin
				ptr_q <= (ptr_q == AW'(MAX_TAPS - 1)) ? '0 : ptr_q + AW'(1);
				if (fill_q != CNT_W'(MAX_TAPS)) fill_q <= fill_q + CNT_W'(1);
				// start the walk at the slot just written
				k_q   <= '0;
				pos_q <= ptr_q;
			end else if (issue) begin
				k_q   <= k_q + CNT_W'(1);
				pos_q <= (pos_q == '0) ? AW'(MAX_TAPS - 1) : pos_q - AW'(1);
			end

			ctl_s1.vld  <= issue;
			ctl_s1.last <= issue & last_tap;
			ctl_s1.hv   <= hist_vld;

			// hold the result until the sink takes it
			if (out_load) begin
				out_vld_q <= 1'b1;
			end else if (result.ready) begin
				out_vld_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (xfer_in && is_filter) begin
			res_q <= item.value;    // pass-through when no taps are in use
		end else if (state_q == ST_DRAIN && mac_done) begin
			res_q <= mac_res;
		end
		if (out_load) begin
			out_data_q <= res_q;
		end
	end

	assign result.valid      = out_vld_q;
	assign result.out_sample = out_data_q;

	fcf_ram u_coef_ram (
		.clk   (clk),
		.we    (coef_we),
		.waddr (coef_waddr),
		.wdata (coef_wdata),
		.raddr (k_q[AW-1:0]),
		.rdata (coef_rd)
	);

	// the sample is written at its transfer, before the walk reads it back
	fcf_ram u_hist_ram (
		.clk   (clk),
		.we    (xfer_in & is_filter),
		.waddr (ptr_q),
		.wdata (item.value),
		.raddr (pos_q),
		.rdata (hist_rd)
	);

	fcf_mac u_mac (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (xfer_in & is_filter),
		.ctl    (ctl_s1),
		.coef   (coef_rd),
		.hist   (hist_rd),
		.done   (mac_done),
		.result (mac_res)
	);

	a_fill_bound: assert property (@(posedge clk) disable iff (!arst_n)
		fill_q <= CNT_W'(MAX_TAPS))
		else $error("history fill count beyond depth");

	a_ptr_fill: assert property (@(posedge clk) disable iff (!arst_n)
		fill_q != CNT_W'(MAX_TAPS) |-> ptr_q == fill_q[AW-1:0])
		else $error("history pointer out of step with fill count");

	a_done_drain: assert property (@(posedge clk) disable iff (!arst_n)
		mac_done |-> state_q == ST_DRAIN)
		else $error("accumulator finished outside drain");

	a_walk_bound: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_RUN |-> k_q < taps_q)
		else $error("tap walk past tap count");

	a_emit_once: assert property (@(posedge clk) disable iff (!arst_n)
		out_load |=> state_q == ST_IDLE && out_vld_q)
		else $error("result not held after load");

endmodule
